### rtl/tpe_pkg.sv
// ----------------------------------------------------------------------------
// tpe_pkg: shared types and constants for the terminal parameter expander
// Character codes, value limits and the job record that the front part
// hands to the back part through the job queue.
// ----------------------------------------------------------------------------
package tpe_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 8;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CHAR_PCT  = 8'h25; // '%'
	localparam logic [7:0] CHAR_I    = 8'h69; // 'i'
	localparam logic [7:0] CHAR_P    = 8'h70; // 'p'
	localparam logic [7:0] CHAR_D    = 8'h64; // 'd'
	localparam logic [7:0] CHAR_ZERO = 8'h30; // '0'
	localparam logic [7:0] CHAR_ONE  = 8'h31; // '1'
	localparam logic [7:0] CHAR_TWO  = 8'h32; // '2'

	localparam logic [7:0] VALUE_MAX = 8'd199;

	// One unit of output work: a literal byte, or a non-zero value to print
	typedef struct packed {
		logic       is_num;
		logic [7:0] val;
	} job_t;

endpackage

### rtl/tpe_queue.sv
// ----------------------------------------------------------------------------
// tpe_queue: short job queue between front and back
// Register-based first-in first-out store; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module tpe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tpe_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output tpe_pkg::job_t head_job,
	output logic          not_empty
);
	import tpe_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### rtl/tpe_front.sv
// ----------------------------------------------------------------------------
// tpe_front: format byte parser
// Accepts one format byte per cycle unless queue_full, updates parameters,
// value stack and parse phase, and queues a job for every byte that outputs.
// ----------------------------------------------------------------------------
module tpe_front #(
	parameter int unsigned STACK_DEPTH = tpe_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    fmt_byte,
	input  logic [7:0]    param_one,
	input  logic [7:0]    param_two,
	input  logic          start_req,
	output logic          job_push,
	output tpe_pkg::job_t job,
	input  logic          queue_full
);
	import tpe_pkg::*;

	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

	typedef enum logic [1:0] {
		PH_LIT,
		PH_PCT,
		PH_PUSH
	} phase_t;

	function automatic logic [7:0] clamp_val(input logic [7:0] v);
		return (v > VALUE_MAX) ? VALUE_MAX : v;
	endfunction

	function automatic logic [7:0] bump_val(input logic [7:0] v);
		return (v >= VALUE_MAX) ? VALUE_MAX : v + 8'd1;
	endfunction

	logic [7:0]       stack_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [7:0]       held_one_q;
	logic [7:0]       held_two_q;
	phase_t           phase_q;

	logic             accept;
	logic [7:0]       clamp_one;
	logic [7:0]       clamp_two;
	logic [CNT_W-1:0] eff_count;
	logic [7:0]       eff_one;
	logic [7:0]       eff_two;
	phase_t           eff_phase;

	logic             do_push;
	logic [7:0]       push_val;
	logic             do_pop;
	logic             do_bump;
	logic [7:0]       top_val;
	logic [IDX_W-1:0] top_idx;
	logic             stack_full;
	phase_t           next_phase;
	logic [CNT_W-1:0] next_count;

	assign in_ready  = !queue_full;
	assign accept    = in_valid && in_ready;

	assign clamp_one = clamp_val(param_one);
	assign clamp_two = clamp_val(param_two);
	assign eff_count = start_req ? CNT_W'(2) : count_q;
	assign eff_one   = start_req ? clamp_one : held_one_q;
	assign eff_two   = start_req ? clamp_two : held_two_q;
	assign eff_phase = start_req ? PH_LIT : phase_q;

	assign stack_full = (eff_count == CNT_W'(STACK_DEPTH));
	assign top_idx    = IDX_W'(count_q - 1'b1);
	assign top_val    = (count_q == '0) ? 8'd0 : stack_q[top_idx];

	always_comb begin
		do_push    = 1'b0;
		push_val   = 8'd0;
		do_pop     = 1'b0;
		do_bump    = 1'b0;
		next_phase = PH_LIT;
		job_push   = 1'b0;
		job.is_num = 1'b0;
		job.val    = fmt_byte;
		unique case (eff_phase)
			PH_PUSH: begin
				do_push = 1'b1;
				if (fmt_byte == CHAR_ONE) begin
					push_val = eff_one;
				end else if (fmt_byte == CHAR_TWO) begin
					push_val = eff_two;
				end
			end
			PH_PCT: begin
				if (fmt_byte == CHAR_I) begin
					do_bump = 1'b1;
				end else if (fmt_byte == CHAR_P) begin
					next_phase = PH_PUSH;
				end else if (fmt_byte == CHAR_D) begin
					// a pop of zero, or from an empty stack, prints nothing
					do_pop     = 1'b1;
					job.is_num = 1'b1;
					job.val    = top_val;
					job_push   = accept && (top_val != 8'd0);
				end
			end
			default: begin
				if (fmt_byte == CHAR_PCT) begin
					next_phase = PH_PCT;
				end else begin
					job_push = accept;
				end
			end
		endcase
	end

	always_comb begin
		next_count = eff_count;
		if (do_push && !stack_full) begin
			next_count = eff_count + 1'b1;
		end else if (do_pop && count_q != '0) begin
			next_count = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			held_one_q <= 8'd0;
			held_two_q <= 8'd0;
			phase_q    <= PH_LIT;
		end else if (accept) begin
			count_q    <= next_count;
			phase_q    <= next_phase;
			held_one_q <= do_bump ? bump_val(eff_one) : eff_one;
			held_two_q <= do_bump ? bump_val(eff_two) : eff_two;
		end
	end

	// Stack entries hold no reset: only entries below the count are read
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < STACK_DEPTH; i++) begin
				if (do_push && !stack_full && eff_count == CNT_W'(i)) begin
					stack_q[i] <= push_val;
				end else if (do_bump && i < 2 && count_q > CNT_W'(i)) begin
					stack_q[i] <= bump_val(stack_q[i]);
				end else if (start_req && i == 0) begin
					stack_q[i] <= clamp_two;
				end else if (start_req && i == 1) begin
					stack_q[i] <= clamp_one;
				end
			end
		end
	end

endmodule

### rtl/tpe_back.sv
// ----------------------------------------------------------------------------
// tpe_back: character emitter
// Takes jobs from the queue, turns values into decimal digits and sends one
// character per cycle while out_ready is high, marking the last of each job.
// ----------------------------------------------------------------------------
module tpe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  tpe_pkg::job_t job,
	output logic          job_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_last
);
	import tpe_pkg::*;

	logic       busy_q;
	logic [1:0] idx_q;
	logic [1:0] num_q;
	logic [7:0] char_q [3];

	logic       on_last;
	logic       load;
	logic [6:0] rest;
	logic [14:0] prod;
	logic [3:0] tens;
	logic [6:0] tens_x10;
	logic [3:0] ones;
	logic [1:0] ld_num;
	logic [7:0] ld_char [3];

	assign on_last   = (idx_q == num_q - 2'd1);
	assign out_valid = busy_q;
	assign out_byte  = char_q[idx_q];
	assign out_last  = on_last;
	assign load      = !busy_q || (out_ready && on_last);
	assign job_pop   = load;

	// Split the value: rest below 100, tens by reciprocal multiply
	always_comb begin
		rest     = (job.val >= 8'd100) ? 7'(job.val - 8'd100) : job.val[6:0];
		prod     = 15'(rest) * 15'd205;
		tens     = prod[14:11];
		tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
		ones     = 4'(rest - tens_x10);
		ld_char[0] = job.val;
		ld_char[1] = 8'd0;
		ld_char[2] = 8'd0;
		ld_num     = 2'd1;
		if (job.is_num) begin
			if (job.val >= 8'd100) begin
				ld_char[0] = CHAR_ONE;
				ld_char[1] = CHAR_ZERO + 8'(tens);
				ld_char[2] = CHAR_ZERO + 8'(ones);
				ld_num     = 2'd3;
			end else if (job.val >= 8'd10) begin
				ld_char[0] = CHAR_ZERO + 8'(tens);
				ld_char[1] = CHAR_ZERO + 8'(ones);
				ld_num     = 2'd2;
			end else begin
				ld_char[0] = CHAR_ZERO + 8'(ones);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
			num_q  <= 2'd1;
		end else if (load) begin
			busy_q <= job_valid;
			idx_q  <= 2'd0;
			num_q  <= ld_num;
		end else if (out_ready) begin
			idx_q  <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= ld_char;
		end
	end

endmodule

### rtl/terminfo_param_expander_core.sv
// ----------------------------------------------------------------------------
// terminfo_param_expander_core: terminal control string expander
// Expands a parameterised terminal control string, one format byte at a
// time, into the characters to send to the terminal.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one format byte per transfer, with the row and
//   column parameters alongside. s_tuser marks the first byte of a string;
//   on that transfer the parameters are latched (clamped to 199) and the
//   value stack is reloaded with the column below the row.
//   Output stream (m_*): one character per transfer; m_tlast marks the
//   final character produced by a format byte. Bytes such as '%', '%p1'
//   or '%i' produce no transfer at all.
//   A byte's job is written into the job queue, and the emitter then
//   loads it into its character registers before the first character
//   is presented on m_tvalid. Throughput: one input byte per cycle; the
//   output side sends one character per cycle while m_tready is high, so a
//   %d printing three digits occupies the emitter for three characters. A
//   four-entry job queue between parser and emitter absorbs such bursts;
//   the parser stalls only when it is full.
//   When the receiver holds m_tready low, the current character holds and
//   the queue fills; s_tready drops once all four entries are taken.
//   Reset clears the stack count, both parameters and the parse phase, and
//   empties the queue and the emitter.
// ----------------------------------------------------------------------------
module terminfo_param_expander_core #(
	parameter int unsigned STACK_DEPTH = tpe_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // fmt_byte[7:0], param_one[15:8], param_two[23:16]
	input  logic        s_tuser,  // start_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte[7:0]
	output logic        m_tlast   // last
);
	import tpe_pkg::*;

	job_t front_job;
	logic front_push;
	logic queue_full;
	job_t head_job;
	logic head_valid;
	logic back_pop;

	// Parser: classify each byte, update stack and parameters
	tpe_front #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.fmt_byte   (s_tdata[7:0]),
		.param_one  (s_tdata[15:8]),
		.param_two  (s_tdata[23:16]),
		.start_req  (s_tuser),
		.job_push   (front_push),
		.job        (front_job),
		.queue_full (queue_full)
	);

	// Hold pending jobs so that each side stalls on its own
	tpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.push_job  (front_job),
		.full      (queue_full),
		.pop       (back_pop),
		.head_job  (head_job),
		.not_empty (head_valid)
	);

	// Emitter: advance one character per output transfer
	tpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.job_pop   (back_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
